FILE: src/bfa_pkg.sv
// ---------------------------------------------------------------------------
// bfa_pkg
// shared types and constants of the bitmap first-free allocator
// ---------------------------------------------------------------------------
package bfa_pkg;

    localparam int IDX_W      = 10;
    localparam int STAT_W     = 2;
    localparam int EIU_W      = 11;
    localparam int REACH_BYTES = 128;

    localparam logic [EIU_W-1:0] EIU_RESET = 11'd1024;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       found;
        logic [2:0] bit_idx;
        logic [7:0] new_byte;
    } t_pick;

endpackage

FILE: src/bfa_bitmap_ram.sv
// ---------------------------------------------------------------------------
// bfa_bitmap_ram
// byte-wide bitmap memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module bfa_bitmap_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/bfa_bit_pick.sv
// ---------------------------------------------------------------------------
// bfa_bit_pick
// finds the lowest clear bit of a bitmap byte and the byte with it set
// ---------------------------------------------------------------------------
module bfa_bit_pick
    import bfa_pkg::*;
(
    input  logic [7:0] i_byte,
    output t_pick      o_pick
);

    always_comb begin
        o_pick.found    = (i_byte != 8'hFF);
        o_pick.bit_idx  = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!i_byte[k]) begin
                o_pick.bit_idx = 3'(k);
            end
        end
        o_pick.new_byte = i_byte | (8'd1 << o_pick.bit_idx);
    end

endmodule

FILE: src/bitmap_first_free_allocator_top.sv
// allocate: scans the bitmap from byte 0, one bitmap byte read per cycle
// free: at most one read-modify-write on the bitmap RAM (none for an untouched byte)
// one word in flight at a time; a finished result waits in the output register
// reset is synchronous; the bitmap reads as all free at once through a
// high-water mark of touched bytes, so no clearing pass is needed
// ---------------------------------------------------------------------------
// bitmap_first_free_allocator_top
// first-fit entry allocator over a byte-wide allocation bitmap in RAM
// ---------------------------------------------------------------------------
module bitmap_first_free_allocator_top
    import bfa_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [EIU_W-1:0]  i_cfg_wdata,      // entries_in_use
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,     // [9:0] entry_index
    input  logic [0:0]        s_axis_tuser,     // [0] opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,     // [9:0] granted_index
    output logic [STAT_W-1:0] m_axis_tuser      // [1:0] status
);

    localparam int MAP_BYTES   = (ENTRIES + 7) / 8;
    localparam int MEM_DEPTH   = (MAP_BYTES < REACH_BYTES) ? MAP_BYTES : REACH_BYTES;
    localparam int WHOLE_BYTES = ((ENTRIES / 8) < REACH_BYTES) ? (ENTRIES / 8) : REACH_BYTES;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MEM_DEPTH + 1);

    t_state             r_state, n_state;
    logic [EIU_W-1:0]   r_eiu;
    logic [CNT_W-1:0]   r_hwm, n_hwm;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_lim, n_lim;
    logic [CNT_W-1:0]   r_chk_ptr, n_chk_ptr;
    logic               r_chk_vld, n_chk_vld;
    logic [ADDR_W-1:0]  r_free_addr, n_free_addr;
    logic [2:0]         r_free_bit, n_free_bit;
    logic [STAT_W-1:0]  r_res_status, n_res_status;
    logic [IDX_W-1:0]   r_res_grant, n_res_grant;
    logic               r_out_valid, n_out_valid;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [IDX_W-1:0]   r_out_grant, n_out_grant;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    t_pick              pick;

    logic               in_op;
    logic [IDX_W-1:0]   in_idx;
    logic [6:0]         in_byte;
    logic               in_range_err;
    logic [CNT_W-1:0]   scan_lim;

    assign in_op   = s_axis_tuser[0];
    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_byte = in_idx[IDX_W-1:3];
    assign in_range_err = ({1'b0, in_idx} >= r_eiu) || (32'(in_idx) >= ENTRIES);
    assign scan_lim = (32'(r_eiu[EIU_W-1:3]) >= WHOLE_BYTES) ? CNT_W'(WHOLE_BYTES)
                                                             : CNT_W'(r_eiu[EIU_W-1:3]);

    bfa_bitmap_ram #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    bfa_bit_pick u_pick (
        .i_byte (rd_data),
        .o_pick (pick)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eiu       <= EIU_RESET;
            r_hwm       <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hwm       <= n_hwm;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_eiu <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_lim        <= n_lim;
        r_chk_ptr    <= n_chk_ptr;
        r_free_addr  <= n_free_addr;
        r_free_bit   <= n_free_bit;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
    end

    always_comb begin
        n_state      = r_state;
        n_hwm        = r_hwm;
        n_ptr        = r_ptr;
        n_lim        = r_lim;
        n_chk_ptr    = r_chk_ptr;
        n_chk_vld    = 1'b0;
        n_free_addr  = r_free_addr;
        n_free_bit   = r_free_bit;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_op == OP_ALLOC) begin
                        n_ptr   = '0;
                        n_lim   = scan_lim;
                        n_state = S_SCAN;
                    end else if (in_range_err) begin
                        n_res_status = ST_RANGE;
                        n_res_grant  = '0;
                        n_state      = S_DONE;
                    end else if ({1'b0, in_byte} >= 8'(r_hwm)) begin
                        // byte never touched, bit already clear
                        n_res_status = ST_OK;
                        n_res_grant  = '0;
                        n_state      = S_DONE;
                    end else begin
                        rd_en       = 1'b1;
                        rd_addr     = ADDR_W'(in_byte);
                        n_free_addr = ADDR_W'(in_byte);
                        n_free_bit  = in_idx[2:0];
                        n_state     = S_FREE;
                    end
                end
            end
            S_FREE: begin
                wr_en        = 1'b1;
                wr_addr      = r_free_addr;
                wr_data      = rd_data & ~(8'd1 << r_free_bit);
                n_res_status = ST_OK;
                n_res_grant  = '0;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                if (r_chk_vld && pick.found) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_chk_ptr[ADDR_W-1:0];
                    wr_data      = pick.new_byte;
                    n_res_status = ST_OK;
                    n_res_grant  = IDX_W'({r_chk_ptr, pick.bit_idx});
                    n_state      = S_DONE;
                end else if (r_ptr >= r_lim) begin
                    n_res_status = ST_FULL;
                    n_res_grant  = '0;
                    n_state      = S_DONE;
                end else if (r_ptr >= r_hwm) begin
                    // first untouched byte reads as all free
                    wr_en        = 1'b1;
                    wr_addr      = r_ptr[ADDR_W-1:0];
                    wr_data      = 8'h01;
                    n_hwm        = r_hwm + 1'b1;
                    n_res_status = ST_OK;
                    n_res_grant  = IDX_W'({r_ptr, 3'd0});
                    n_state      = S_DONE;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = r_ptr[ADDR_W-1:0];
                    n_chk_ptr = r_ptr;
                    n_chk_vld = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_grant  = r_res_grant;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_grant);
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: src/bfa_checker.sv
// ---------------------------------------------------------------------------
// bfa_checker
// port-level checks of the allocator, bound to the top level
// ---------------------------------------------------------------------------
module bfa_checker
    import bfa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [15:0]       m_axis_tdata,
    input logic [STAT_W-1:0] m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped before taken");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
                           m_axis_tuser == ST_RANGE))
        else $error("undefined status code");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 16'd0)
        else $error("nonzero index on failed request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in work");

endmodule

bind bitmap_first_free_allocator_top bfa_checker u_bfa_checker (.*);
